FILE: hw/rtl/imuc_pkg.sv
package imuc_pkg;

    localparam int NUM_AXES   = 3;
    localparam int BYTE_W     = 8;
    localparam int RAW_W      = 2 * BYTE_W;
    localparam int SENS_W     = 24;
    localparam int BIAS_W     = 16;
    localparam int BIAS_SH    = 16;
    localparam int COEF_W     = 16;
    localparam int ROW_W      = NUM_AXES * COEF_W;
    localparam int CAL_W      = 40;
    localparam int CFG_DATA_W = ROW_W;
    localparam int CFG_IDX_W  = 3;

    // raw * sensitivity fits in 41 bits signed, and so does the biased value
    localparam int SCALED_W   = RAW_W + SENS_W + 1;
    // scaled value split for the coefficient products
    localparam int LO_W       = 24;
    localparam int HI_W       = SCALED_W - LO_W;
    localparam int PLO_W      = COEF_W + LO_W + 1;
    localparam int PHI_W      = COEF_W + HI_W;
    localparam int PROD_W     = COEF_W + SCALED_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int RND_W      = ACC_W + 1;
    localparam int ROUND_SH   = 22;
    localparam int Q_W        = RND_W - ROUND_SH;

    // pipeline stages: product, bias, partial products, products, sum, output
    localparam int STAGES     = 6;

    localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_X      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_Y      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_Z      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_X       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z       = 3'd6;

    localparam logic [SENS_W-1:0] SENS_RESET  = 24'd65536;
    localparam logic [ROW_W-1:0]  ROW_X_RESET = 48'h0000_0000_4000;
    localparam logic [ROW_W-1:0]  ROW_Y_RESET = 48'h0000_4000_0000;
    localparam logic [ROW_W-1:0]  ROW_Z_RESET = 48'h4000_0000_0000;

    typedef logic signed [SCALED_W-1:0] scaled_t;
    typedef logic signed [CAL_W-1:0]    cal_t;

    // per-stage load enables
    typedef struct packed {
        logic mul;
        logic bias;
        logic part;
        logic prod;
        logic sum;
        logic outp;
    } imuc_adv_t;

endpackage

FILE: hw/rtl/imuc_scale_lane.sv
module imuc_scale_lane
    import imuc_pkg::*;
(
    input  logic                clk,
    input  imuc_adv_t           adv,
    input  logic [BYTE_W-1:0]   low,
    input  logic [BYTE_W-1:0]   high,
    input  logic [SENS_W-1:0]   sensitivity,
    input  logic [BIAS_W-1:0]   bias,
    output scaled_t             scaled
);

    scaled_t mul_reg;
    scaled_t mul_next;
    scaled_t scaled_reg;
    scaled_t scaled_next;
    scaled_t bias_shifted;

    always_comb
    begin
        mul_next     = SCALED_W'($signed({high, low}))
                       * SCALED_W'($signed({1'b0, sensitivity}));
        bias_shifted = $signed({{(SCALED_W - BIAS_W - BIAS_SH){bias[BIAS_W-1]}},
                                bias, {BIAS_SH{1'b0}}});
        scaled_next  = mul_reg - bias_shifted;
    end

    always_ff @(posedge clk)
    begin
        if (adv.mul)
        begin
            mul_reg <= mul_next;
        end
        if (adv.bias)
        begin
            scaled_reg <= scaled_next;
        end
    end

    assign scaled = scaled_reg;

endmodule

FILE: hw/rtl/imuc_mix_lane.sv
module imuc_mix_lane
    import imuc_pkg::*;
(
    input  logic                      clk,
    input  imuc_adv_t                 adv,
    input  logic [ROW_W-1:0]          row,
    input  scaled_t [NUM_AXES-1:0]    scaled,
    output cal_t                      cal
);

    localparam logic signed [RND_W-1:0] ROUND_HALF = RND_W'(1) <<< (ROUND_SH - 1);
    localparam logic signed [CAL_W:0]   SAT_HI = (CAL_W + 1)'((64'sd1 <<< (CAL_W - 1)) - 1);
    localparam logic signed [CAL_W:0]   SAT_LO = -((CAL_W + 1)'(64'sd1 <<< (CAL_W - 1)));

    logic signed [PLO_W-1:0]  plo_reg  [NUM_AXES];
    logic signed [PLO_W-1:0]  plo_next [NUM_AXES];
    logic signed [PHI_W-1:0]  phi_reg  [NUM_AXES];
    logic signed [PHI_W-1:0]  phi_next [NUM_AXES];
    logic signed [PROD_W-1:0] prod_reg [NUM_AXES];
    logic signed [PROD_W-1:0] prod_next[NUM_AXES];
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [RND_W-1:0]  rnd;
    logic signed [Q_W-1:0]    quot;
    logic signed [CAL_W:0]    quot_wide;
    cal_t                     cal_reg;
    cal_t                     cal_next;

    always_comb
    begin
        for (int c = 0; c < NUM_AXES; c++)
        begin
            plo_next[c] = PLO_W'($signed(row[c*COEF_W +: COEF_W]))
                          * PLO_W'($signed({1'b0, scaled[c][LO_W-1:0]}));
            phi_next[c] = PHI_W'($signed(row[c*COEF_W +: COEF_W]))
                          * PHI_W'($signed(scaled[c][SCALED_W-1:LO_W]));
            prod_next[c] = $signed({phi_reg[c], {LO_W{1'b0}}})
                           + $signed({{(PROD_W - PLO_W){plo_reg[c][PLO_W-1]}}, plo_reg[c]});
        end
        acc_next = ACC_W'(prod_reg[0]) + ACC_W'(prod_reg[1]) + ACC_W'(prod_reg[2]);

        // round to nearest, ties up, then floor shift
        rnd       = RND_W'(acc_reg) + ROUND_HALF;
        quot      = rnd[RND_W-1:ROUND_SH];
        quot_wide = (CAL_W + 1)'(quot);
        if (quot_wide > SAT_HI)
        begin
            cal_next = SAT_HI[CAL_W-1:0];
        end
        else if (quot_wide < SAT_LO)
        begin
            cal_next = SAT_LO[CAL_W-1:0];
        end
        else
        begin
            cal_next = quot_wide[CAL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_AXES; c++)
        begin
            if (adv.part)
            begin
                plo_reg[c] <= plo_next[c];
                phi_reg[c] <= phi_next[c];
            end
            if (adv.prod)
            begin
                prod_reg[c] <= prod_next[c];
            end
        end
        if (adv.sum)
        begin
            acc_reg <= acc_next;
        end
        if (adv.outp)
        begin
            cal_reg <= cal_next;
        end
    end

    assign cal = cal_reg;

endmodule

FILE: hw/rtl/imu_axis_calibrator_unit.sv
// each sample passes the product, bias, partial product, product, sum and output registers
// throughput: one sample per cycle while the output is not stalled; each axis has its own scale and mix lane
// stalls back up stage by stage, so empty stages still take a new transfer
// reset (rst_n low, async): pipeline emptied, registers at identity calibration
// (sensitivity 1.0, zero biases, identity matrix); data registers not reset
module imu_axis_calibrator_unit
    import imuc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // configuration write port
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // sample input
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [BYTE_W-1:0]     x_low,
    input  logic [BYTE_W-1:0]     x_high,
    input  logic [BYTE_W-1:0]     y_low,
    input  logic [BYTE_W-1:0]     y_high,
    input  logic [BYTE_W-1:0]     z_low,
    input  logic [BYTE_W-1:0]     z_high,

    // calibrated output
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [CAL_W-1:0] x_cal,
    output logic signed [CAL_W-1:0] y_cal,
    output logic signed [CAL_W-1:0] z_cal
);

    // configuration registers
    logic [SENS_W-1:0] sens_reg;
    logic [BIAS_W-1:0] bias_reg [NUM_AXES];
    logic [ROW_W-1:0]  row_reg  [NUM_AXES];

    // pipeline occupancy, one bit per stage
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] en;
    imuc_adv_t         adv;

    logic [BYTE_W-1:0]     low_bytes  [NUM_AXES];
    logic [BYTE_W-1:0]     high_bytes [NUM_AXES];
    scaled_t [NUM_AXES-1:0] scaled;
    cal_t                  cal [NUM_AXES];

    // register writes, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_reg    <= SENS_RESET;
            bias_reg[0] <= '0;
            bias_reg[1] <= '0;
            bias_reg[2] <= '0;
            row_reg[0]  <= ROW_X_RESET;
            row_reg[1]  <= ROW_Y_RESET;
            row_reg[2]  <= ROW_Z_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SENSITIVITY: sens_reg    <= cfg_data[SENS_W-1:0];
                REG_BIAS_X:      bias_reg[0] <= cfg_data[BIAS_W-1:0];
                REG_BIAS_Y:      bias_reg[1] <= cfg_data[BIAS_W-1:0];
                REG_BIAS_Z:      bias_reg[2] <= cfg_data[BIAS_W-1:0];
                REG_ROW_X:       row_reg[0]  <= cfg_data[ROW_W-1:0];
                REG_ROW_Y:       row_reg[1]  <= cfg_data[ROW_W-1:0];
                REG_ROW_Z:       row_reg[2]  <= cfg_data[ROW_W-1:0];
                default:         ;
            endcase
        end
    end

    // a stage loads when it is empty or its content moves on
    always_comb
    begin
        en[STAGES-1] = !valid_reg[STAGES-1] || !out_stall;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
        valid_next[0] = in_valid;
        for (int i = 1; i < STAGES; i++)
        begin
            valid_next[i] = valid_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_next[i];
                end
            end
        end
    end

    assign adv = '{mul: en[0], bias: en[1], part: en[2],
                   prod: en[3], sum: en[4], outp: en[5]};

    // little-endian byte pairs per axis
    assign low_bytes[0]  = x_low;
    assign high_bytes[0] = x_high;
    assign low_bytes[1]  = y_low;
    assign high_bytes[1] = y_high;
    assign low_bytes[2]  = z_low;
    assign high_bytes[2] = z_high;

    // scale lanes: raw * sensitivity - bias
    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_scale
        imuc_scale_lane u_scale (
            .clk         (clk),
            .adv         (adv),
            .low         (low_bytes[a]),
            .high        (high_bytes[a]),
            .sensitivity (sens_reg),
            .bias        (bias_reg[a]),
            .scaled      (scaled[a])
        );
    end

    // mix lanes: one matrix row each, merging all three scaled axes
    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_mix
        imuc_mix_lane u_mix (
            .clk    (clk),
            .adv    (adv),
            .row    (row_reg[a]),
            .scaled (scaled),
            .cal    (cal[a])
        );
    end

    assign in_stall  = !en[0];
    assign out_valid = valid_reg[STAGES-1];
    assign x_cal     = cal[0];
    assign y_cal     = cal[1];
    assign z_cal     = cal[2];

    // input only backs up when every stage holds a sample and output is stalled
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> ((&valid_reg) && out_stall))
        else $error("input stalled with room in the pipeline");

    // an input transfer lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> valid_reg[0])
        else $error("accepted sample lost at pipeline entry");

    // with no output stall the last stage follows the one before it
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(out_stall) |-> (out_valid == $past(valid_reg[STAGES-2])))
        else $error("output valid out of step with pipeline");

endmodule
